// ===== rtl/sqd_pkg.sv =====
package sqd_pkg;

	localparam int ACT_BITS = 4;
	localparam logic [ACT_BITS-1:0] ACT_RESET = 4'd8;

	// operation codes
	localparam logic [1:0] KIND_PUSH     = 2'd0;
	localparam logic [1:0] KIND_POP      = 2'd1;
	localparam logic [1:0] KIND_SHUTDOWN = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_CLOSED     = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_SHUT       = 3'd4;
	localparam logic [2:0] ST_BAD_WORKER = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] task_id;
		logic        is_pinned;
		logic [2:0]  worker;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  chosen_worker;
		logic [15:0] popped_task;
		logic        newly_pinned;
		logic [7:0]  total_queued;
	} res_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EXEC,
		S_RESP
	} state_t;

endpackage

// ===== rtl/shortest_queue_task_dispatcher_top.sv =====
// channel   | ports                       | handshake
// ----------+-----------------------------+-------------------------------------
// command   | start, busy, cmd            | word taken at edge with start & !busy
// result    | done, result                | one-cycle strobe, cannot be held off
// config    | cfg_we, cfg_wdata           | active_workers written when cfg_we
//
// Start to done strobe: an unpinned push scans the N active workers, one occupancy
// read and compare per cycle through the queue table port; a pop or pinned push
// scans one entry; both then execute. Shutdown and rejected words skip to response.
// busy drops in the cycle done is raised, so the next word can go in then.
// Reset clears all queue state at once through per-queue valid bits.
module shortest_queue_task_dispatcher_top #(
	parameter int WORKERS     = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_BITS   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  sqd_pkg::cmd_t                  cmd,
	output logic                           done,
	output sqd_pkg::res_t                  result,
	input  logic                           cfg_we,
	input  logic [sqd_pkg::ACT_BITS-1:0]   cfg_wdata
);

	localparam int WW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int OW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = $clog2(WORKERS * QUEUE_DEPTH);
	localparam int TW = $clog2(WORKERS * QUEUE_DEPTH + 1);
	localparam int EW = 2 * PW + OW + 1;
	localparam int DW = TASK_BITS + 1;
	localparam int CW = sqd_pkg::ACT_BITS;

	typedef struct packed {
		logic          closed;
		logic [OW-1:0] occ;
		logic [PW-1:0] tail;
		logic [PW-1:0] head;
	} qent_t;

	sqd_pkg::state_t state_q, state_d;

	logic [CW-1:0] cfg_q;
	logic [CW-1:0] act;
	logic          shut_q;
	logic [TW-1:0] total_q;
	logic          done_q;
	sqd_pkg::res_t result_q;

	sqd_pkg::cmd_t op_q;
	logic [CW-1:0] i_q, last_q, pidx_q;
	logic          idone_q, pend_q, first_q;
	qent_t         best_q;
	logic [WW-1:0] bidx_q;
	logic [2:0]    status_q, chosen_q;
	logic          popok_q;

	// decode of the incoming word
	logic          w_bad;
	logic          dec_scan;
	logic [2:0]    dec_status, dec_chosen;
	logic [CW-1:0] dec_first, dec_last;

	// execute step
	logic          issue;
	logic [2:0]    ex_status;
	logic          ex_popok, ex_inc, ex_dec;
	logic [PW-1:0] ptr_sel;

	logic          qt_we, qt_re;
	qent_t         qt_wdata, qt_rdata;
	logic [WW-1:0] qt_raddr;

	logic          tm_we, tm_re;
	logic [AW-1:0] tm_addr;
	logic [DW-1:0] tm_wdata, tm_rdata;

	always_comb begin
		if (cfg_q == '0) begin
			act = CW'(1);
		end else if (32'(cfg_q) > WORKERS) begin
			act = CW'(WORKERS);
		end else begin
			act = cfg_q;
		end
	end

	always_comb begin
		w_bad      = {1'b0, cmd.worker} >= act;
		dec_scan   = 1'b0;
		dec_status = sqd_pkg::ST_OK;
		dec_chosen = 3'd0;
		dec_first  = {1'b0, cmd.worker};
		dec_last   = {1'b0, cmd.worker};
		case (cmd.kind)
			sqd_pkg::KIND_PUSH: begin
				if (shut_q) begin
					dec_status = sqd_pkg::ST_SHUT;
				end else if (cmd.is_pinned && w_bad) begin
					dec_status = sqd_pkg::ST_BAD_WORKER;
					dec_chosen = cmd.worker;
				end else if (cmd.is_pinned) begin
					dec_scan = 1'b1;
				end else begin
					dec_scan  = 1'b1;
					dec_first = '0;
					dec_last  = act - CW'(1);
				end
			end
			sqd_pkg::KIND_POP: begin
				dec_chosen = cmd.worker;
				if (w_bad) begin
					dec_status = sqd_pkg::ST_BAD_WORKER;
				end else begin
					dec_scan = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d   = state_q;
		issue     = 1'b0;
		qt_re     = 1'b0;
		qt_we     = 1'b0;
		qt_wdata  = best_q;
		tm_we     = 1'b0;
		tm_re     = 1'b0;
		ex_status = sqd_pkg::ST_OK;
		ex_popok  = 1'b0;
		ex_inc    = 1'b0;
		ex_dec    = 1'b0;
		case (state_q)
			sqd_pkg::S_IDLE: begin
				if (start) begin
					state_d = dec_scan ? sqd_pkg::S_SCAN : sqd_pkg::S_RESP;
				end
			end
			sqd_pkg::S_SCAN: begin
				issue = !idone_q;
				qt_re = issue;
				if (pend_q && (pidx_q == last_q)) begin
					state_d = sqd_pkg::S_EXEC;
				end
			end
			sqd_pkg::S_EXEC: begin
				state_d = sqd_pkg::S_RESP;
				if (op_q.kind == sqd_pkg::KIND_PUSH) begin
					if (best_q.occ >= OW'(QUEUE_DEPTH)) begin
						ex_status = sqd_pkg::ST_FULL;
					end else begin
						tm_we         = 1'b1;
						qt_we         = 1'b1;
						qt_wdata.tail = (best_q.tail == PW'(QUEUE_DEPTH - 1)) ? '0
							: best_q.tail + PW'(1);
						qt_wdata.occ  = best_q.occ + OW'(1);
						ex_inc        = 1'b1;
					end
				end else begin
					if (best_q.closed) begin
						ex_status = sqd_pkg::ST_CLOSED;
					end else if (best_q.occ != '0) begin
						tm_re         = 1'b1;
						qt_we         = 1'b1;
						qt_wdata.head = (best_q.head == PW'(QUEUE_DEPTH - 1)) ? '0
							: best_q.head + PW'(1);
						qt_wdata.occ  = best_q.occ - OW'(1);
						ex_dec        = 1'b1;
						ex_popok      = 1'b1;
					end else if (shut_q) begin
						// empty after shutdown: latch closed for good
						qt_we           = 1'b1;
						qt_wdata.closed = 1'b1;
						ex_status       = sqd_pkg::ST_CLOSED;
					end else begin
						ex_status = sqd_pkg::ST_EMPTY;
					end
				end
			end
			sqd_pkg::S_RESP: begin
				state_d = sqd_pkg::S_IDLE;
			end
			default: begin
				state_d = sqd_pkg::S_IDLE;
			end
		endcase
	end

	assign qt_raddr = WW'(i_q);
	assign ptr_sel  = (op_q.kind == sqd_pkg::KIND_PUSH) ? best_q.tail : best_q.head;
	assign tm_addr  = AW'(32'(bidx_q) * QUEUE_DEPTH) + AW'(ptr_sel);
	assign tm_wdata = {op_q.is_pinned, TASK_BITS'(op_q.task_id)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sqd_pkg::S_IDLE;
			cfg_q   <= sqd_pkg::ACT_RESET;
			shut_q  <= 1'b0;
			total_q <= '0;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
			idone_q <= 1'b0;
			first_q <= 1'b1;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == sqd_pkg::S_RESP);
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (state_q == sqd_pkg::S_IDLE && start && cmd.kind == sqd_pkg::KIND_SHUTDOWN) begin
				shut_q <= 1'b1;
			end
			if (ex_inc) begin
				total_q <= total_q + TW'(1);
			end else if (ex_dec) begin
				total_q <= total_q - TW'(1);
			end
			if (state_q == sqd_pkg::S_IDLE) begin
				pend_q  <= 1'b0;
				idone_q <= 1'b0;
				first_q <= 1'b1;
			end else if (state_q == sqd_pkg::S_SCAN) begin
				pend_q <= issue;
				if (issue && (i_q == last_q)) begin
					idone_q <= 1'b1;
				end
				if (pend_q) begin
					first_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sqd_pkg::S_IDLE && start) begin
			op_q     <= cmd;
			i_q      <= dec_first;
			last_q   <= dec_last;
			status_q <= dec_status;
			chosen_q <= dec_chosen;
			popok_q  <= 1'b0;
		end
		if (state_q == sqd_pkg::S_SCAN) begin
			if (issue) begin
				i_q <= i_q + CW'(1);
			end
			pidx_q <= i_q;
			// strict less-than keeps the lowest index on a tie
			if (pend_q && (first_q || qt_rdata.occ < best_q.occ)) begin
				best_q <= qt_rdata;
				bidx_q <= WW'(pidx_q);
			end
		end
		if (state_q == sqd_pkg::S_EXEC) begin
			status_q <= ex_status;
			chosen_q <= 3'(bidx_q);
			popok_q  <= ex_popok;
		end
		if (state_q == sqd_pkg::S_RESP) begin
			result_q.status        <= status_q;
			result_q.chosen_worker <= chosen_q;
			result_q.popped_task   <= popok_q ? 16'(tm_rdata[TASK_BITS-1:0]) : 16'd0;
			result_q.newly_pinned  <= popok_q & ~tm_rdata[TASK_BITS];
			result_q.total_queued  <= (32'(total_q) > 255) ? 8'hFF : 8'(total_q);
		end
	end

	sqd_qtab #(
		.DEPTH (WORKERS),
		.DW    (EW)
	) u_qtab (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (qt_we),
		.waddr (bidx_q),
		.wdata (qt_wdata),
		.re    (qt_re),
		.raddr (qt_raddr),
		.rdata (qt_rdata)
	);

	sqd_tmem #(
		.DEPTH (WORKERS * QUEUE_DEPTH),
		.DW    (DW)
	) u_tmem (
		.clk   (clk),
		.we    (tm_we),
		.re    (tm_re),
		.addr  (tm_addr),
		.wdata (tm_wdata),
		.rdata (tm_rdata)
	);

	assign busy   = (state_q != sqd_pkg::S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/sqd_qtab.sv =====
// Per-queue state table: one entry per worker, valid bits make unwritten
// entries read as zero right after reset.
module sqd_qtab #(
	parameter int DEPTH = 8,
	parameter int DW    = 14
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [DW-1:0]                           wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [DW-1:0]                           rdata
);

	logic [DW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [DW-1:0]    rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sqd_tmem.sv =====
// Task word storage, single port, registered read.
module sqd_tmem #(
	parameter int DEPTH = 128,
	parameter int DW    = 17
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   addr,
	input  logic [DW-1:0]              wdata,
	output logic [DW-1:0]              rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/sqd_checker.sv =====
module sqd_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input sqd_pkg::res_t result
);

	// every result comes out of a word that was being worked on
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without prior busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results for one word");

	a_quiet_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != sqd_pkg::ST_OK)
			|-> (result.popped_task == 16'd0 && !result.newly_pinned))
		else $error("pop fields set on a failed word");

	a_shut_chosen: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == sqd_pkg::ST_SHUT) |-> (result.chosen_worker == 3'd0))
		else $error("chosen worker set on a push after shutdown");

endmodule

bind shortest_queue_task_dispatcher_top sqd_checker u_sqd_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

// ===== sim/sqd_dispatch_checker.sv =====
module sqd_dispatch_checker #(
	parameter int WORKERS     = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  sqd_pkg::cmd_t                cmd,
	input  logic                         done,
	input  sqd_pkg::res_t                result,
	input  logic                         cfg_we,
	input  logic [sqd_pkg::ACT_BITS-1:0] cfg_wdata,
	output int                           fail_count,
	output int                           outstanding,
	output int                           checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import sqd_pkg::*;

	// shadow of the dispatcher: task id plus pinned flag per slot
	logic [16:0]         task_mem [WORKERS][QUEUE_DEPTH];
	int                  head_idx [WORKERS];
	int                  tail_idx [WORKERS];
	int                  fill     [WORKERS];
	logic                closed_q [WORKERS];
	logic                shut_seen;
	logic [ACT_BITS-1:0] act_reg;

	res_t pending_responses [$];
	res_t want;
	int   mismatches;
	int   checked_n;
	int   queued_n;

	assign fail_count  = mismatches;
	assign outstanding = queued_n;
	assign checked     = checked_n;

	function automatic res_t route_word(cmd_t c);
		res_t        r;
		int          a;
		int          t;
		int          w;
		int          sum;
		logic [16:0] entry;
		r = '0;
		a = int'(act_reg);
		if (a < 1) a = 1;
		if (a > WORKERS) a = WORKERS;
		w = int'(c.worker);
		case (c.kind)
			KIND_PUSH: begin
				if (shut_seen) begin
					r.status = ST_SHUT;
				end else if (c.is_pinned && w >= a) begin
					r.status        = ST_BAD_WORKER;
					r.chosen_worker = c.worker;
				end else begin
					t = w;
					if (!c.is_pinned) begin
						// join shortest queue, lowest index wins a tie
						t = 0;
						for (int i = 1; i < a; i++)
							if (fill[i] < fill[t]) t = i;
					end
					r.chosen_worker = 3'(t);
					if (fill[t] >= QUEUE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						task_mem[t][tail_idx[t]] = {c.is_pinned, c.task_id};
						tail_idx[t] = (tail_idx[t] + 1) % QUEUE_DEPTH;
						fill[t]++;
						r.status = ST_OK;
					end
				end
			end
			KIND_POP: begin
				r.chosen_worker = c.worker;
				if (w >= a) begin
					r.status = ST_BAD_WORKER;
				end else if (closed_q[w]) begin
					r.status = ST_CLOSED;
				end else if (fill[w] > 0) begin
					entry          = task_mem[w][head_idx[w]];
					r.popped_task  = entry[15:0];
					r.newly_pinned = ~entry[16];
					head_idx[w]    = (head_idx[w] + 1) % QUEUE_DEPTH;
					fill[w]--;
					r.status = ST_OK;
				end else if (shut_seen) begin
					// empty after shutdown latches closed
					closed_q[w] = 1'b1;
					r.status    = ST_CLOSED;
				end else begin
					r.status = ST_EMPTY;
				end
			end
			KIND_SHUTDOWN: shut_seen = 1'b1;
			default: ;
		endcase
		sum = 0;
		for (int i = 0; i < WORKERS; i++) sum += fill[i];
		r.total_queued = (sum > 255) ? 8'd255 : 8'(sum);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WORKERS; i++) begin
				head_idx[i] = 0;
				tail_idx[i] = 0;
				fill[i]     = 0;
				closed_q[i] = 1'b0;
			end
			shut_seen = 1'b0;
			act_reg   = ACT_RESET;
			pending_responses.delete();
			mismatches = 0;
			checked_n  = 0;
			queued_n  <= 0;
		end else begin
			if (cfg_we) act_reg = cfg_wdata;
			// a response leaves before a new word enters in the same cycle
			if (done) begin
				if (pending_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: response with none expected: ", $time,
							"st=%0d wk=%0d task=%h pin=%0d tot=%0d",
							result.status, result.chosen_worker, result.popped_task,
							result.newly_pinned, result.total_queued);
				end else begin
					want = pending_responses.pop_front();
					checked_n++;
					if (result.status !== want.status ||
					    result.chosen_worker !== want.chosen_worker ||
					    result.popped_task !== want.popped_task ||
					    result.newly_pinned !== want.newly_pinned ||
					    result.total_queued !== want.total_queued) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch ", $time,
								"exp st=%0d wk=%0d task=%h pin=%0d tot=%0d",
								want.status, want.chosen_worker, want.popped_task,
								want.newly_pinned, want.total_queued,
								" | got st=%0d wk=%0d task=%h pin=%0d tot=%0d",
								result.status, result.chosen_worker, result.popped_task,
								result.newly_pinned, result.total_queued);
					end
				end
			end
			if (start && !busy) pending_responses = {pending_responses, route_word(cmd)};
			queued_n <= pending_responses.size();
		end
	end

endmodule

// ===== sim/tb_shortest_queue_task_dispatcher_top.sv =====
module tb_shortest_queue_task_dispatcher_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sqd_pkg::*;

	localparam int         WORKERS     = 8;
	localparam int         QUEUE_DEPTH = 16;
	localparam int         TASK_BITS   = 16;
	localparam int         STALL_LIMIT = 2000;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	cmd_t                cmd       = '0;
	logic                done;
	res_t                result;
	logic                cfg_we    = 1'b0;
	logic [ACT_BITS-1:0] cfg_wdata = ACT_RESET;

	int fails;
	int outstanding;
	int checked;
	int idle_pct;
	int cur_act;
	int sent_words;
	int n_settings;
	int idle_cycles;

	shortest_queue_task_dispatcher_top #(
		.WORKERS    (WORKERS),
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TASK_BITS  (TASK_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sqd_dispatch_checker #(
		.WORKERS    (WORKERS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.done       (done),
		.result     (result),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fails),
		.outstanding(outstanding),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic cmd_t word(logic [1:0] k, logic [15:0] id, logic pin, logic [2:0] w);
		cmd_t c;
		c.kind      = k;
		c.task_id   = id;
		c.is_pinned = pin;
		c.worker    = w;
		return c;
	endfunction

	function automatic cmd_t make_word(int push_pct, int pop_pct, int shut_pct);
		cmd_t c;
		int   roll;
		c.task_id   = 16'($urandom_range(16'hFFFF));
		c.is_pinned = 1'($urandom_range(1));
		// mostly workers in use, some out of range
		c.worker = ($urandom_range(3) == 0) ? 3'($urandom_range(7))
		                                    : 3'($urandom_range(cur_act - 1));
		roll = $urandom_range(99);
		if (roll < push_pct)
			c.kind = KIND_PUSH;
		else if (roll < push_pct + pop_pct)
			c.kind = KIND_POP;
		else if (roll < push_pct + pop_pct + shut_pct)
			c.kind = KIND_SHUTDOWN;
		else
			c.kind = KIND_UNUSED;
		return c;
	endfunction

	// start stays high across back-to-back words
	task automatic send_word(cmd_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sent_words++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
	endtask

	task automatic write_active(logic [ACT_BITS-1:0] v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_act  = (v == 0) ? 1 : (int'(v) > WORKERS) ? WORKERS : int'(v);
		n_settings++;
	endtask

	task automatic run_phase(logic [ACT_BITS-1:0] v, int idle, int push_pct, int pop_pct,
	                         int shut_pct, int count);
		write_active(v);
		idle_pct = idle;
		repeat (count) begin
			if ($urandom_range(99) < 3) drain();
			send_word(make_word(push_pct, pop_pct, shut_pct));
		end
	endtask

	initial begin
		idle_pct   = 0;
		cur_act    = WORKERS;
		sent_words = 0;
		n_settings = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opening words at the reset worker count
		send_word(word(KIND_POP, 16'h0000, 1'b0, 3'd0));
		send_word(word(KIND_PUSH, 16'h0000, 1'b0, 3'd5));
		send_word(word(KIND_PUSH, 16'hFFFF, 1'b0, 3'd0));
		send_word(word(KIND_PUSH, 16'hA5A5, 1'b1, 3'd7));
		send_word(word(KIND_PUSH, 16'h5A5A, 1'b0, 3'd7));
		send_word(word(KIND_POP, 16'hFFFF, 1'b1, 3'd0));
		send_word(word(KIND_POP, 16'h0000, 1'b0, 3'd7));
		send_word(word(KIND_POP, 16'h0000, 1'b0, 3'd7));
		send_word(word(KIND_UNUSED, 16'hFFFF, 1'b1, 3'd7));
		send_word(word(KIND_PUSH, 16'h1234, 1'b1, 3'd0));
		write_active(4'd2);
		send_word(word(KIND_PUSH, 16'h4321, 1'b1, 3'd5));
		send_word(word(KIND_POP, 16'h0000, 1'b0, 3'd5));
		send_word(word(KIND_PUSH, 16'h00FF, 1'b1, 3'd1));
		send_word(word(KIND_PUSH, 16'hFF00, 1'b0, 3'd6));
		send_word(word(KIND_POP, 16'h0000, 1'b0, 3'd2));

		// random traffic before shutdown; push-heavy phases reach full queues
		run_phase(4'd8,  0,  55, 40, 0, 70);
		run_phase(4'd1,  87, 80, 15, 0, 50);
		run_phase(4'd15, 0,  70, 25, 0, 70);
		run_phase(4'd0,  22, 40, 55, 0, 40);
		run_phase(4'd3,  87, 50, 45, 0, 50);
		run_phase(4'd8,  22, 30, 65, 0, 40);

		// shutdown, then pushes after it and pop-heavy random traffic
		write_active(4'd3);
		idle_pct = 22;
		send_word(word(KIND_SHUTDOWN, 16'hFFFF, 1'b1, 3'd7));
		send_word(word(KIND_PUSH, 16'hBEEF, 1'b0, 3'd0));
		send_word(word(KIND_PUSH, 16'hCAFE, 1'b1, 3'd7));
		send_word(word(KIND_POP, 16'h0000, 1'b0, 3'd6));
		send_word(word(KIND_SHUTDOWN, 16'h0000, 1'b0, 3'd0));
		run_phase(4'd3, 87, 10, 75, 5, 40);
		run_phase(4'd8, 0,   5, 90, 2, 160);

		drain();
		repeat (20) @(posedge clk);
		$display("Summary: %0d command words over %0d worker-count settings, ",
			sent_words, n_settings, "%0d responses checked", checked);
		$display("Covered pinned and shortest-queue pushes, full and bad-worker rejects,",
			" pops through shutdown to closed");
		if (fails == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/sqd_pkg.sv
rtl/sqd_qtab.sv
rtl/sqd_tmem.sv
rtl/shortest_queue_task_dispatcher_top.sv
rtl/sqd_checker.sv
sim/sqd_dispatch_checker.sv
sim/tb_shortest_queue_task_dispatcher_top.sv
